FILE: hw/rtl/hpm_pkg.sv
package hpm_pkg;

  localparam logic [16:0] ONE_Q16     = 17'd65536;
  localparam logic [14:0] MIN_MAX_DEG = 15'd256;
  localparam logic [16:0] EYE_DEN_MIN = 17'd7;
  localparam int          DIV_STEPS   = 16;

  // configuration register indexes
  localparam logic [2:0] CFG_MIN_CONF   = 3'd0;
  localparam logic [2:0] CFG_DEADZONE   = 3'd1;
  localparam logic [2:0] CFG_YAW_MAX    = 3'd2;
  localparam logic [2:0] CFG_PITCH_MAX  = 3'd3;
  localparam logic [2:0] CFG_EYE_THR    = 3'd4;
  localparam logic [2:0] CFG_WEIGHT     = 3'd5;
  localparam logic [2:0] CFG_ALPHA      = 3'd6;
  localparam logic [2:0] CFG_FALLBACK   = 3'd7;

  localparam logic [1:0] GATE_OK       = 2'd0;
  localparam logic [1:0] GATE_NO_FACE  = 2'd1;
  localparam logic [1:0] GATE_LOW_CONF = 2'd2;
  localparam logic [1:0] GATE_INVALID  = 2'd3;

  localparam logic [2:0] FB_NONE        = 3'd0;
  localparam logic [2:0] FB_TRACKER_ERR = 3'd4;
  localparam logic [2:0] FB_DISABLED    = 3'd5;

  typedef logic [3:0] step_t;

  // blend steps of the shared mix unit, in order
  localparam step_t STEP_FB_YAW    = 4'd0;
  localparam step_t STEP_FB_PITCH  = 4'd1;
  localparam step_t STEP_FB_EYE    = 4'd2;
  localparam step_t STEP_SM_YAW    = 4'd3;
  localparam step_t STEP_SM_PITCH  = 4'd4;
  localparam step_t STEP_SM_EYE    = 4'd5;
  localparam step_t STEP_HT_YAW    = 4'd6;
  localparam step_t STEP_HT_PITCH  = 4'd7;
  localparam step_t STEP_ET_BOTH   = 4'd8;
  localparam step_t STEP_ET_LEFT   = 4'd9;
  localparam step_t STEP_ET_RIGHT  = 4'd10;

  typedef struct packed {
    logic  capture;
    logic  div_init;
    logic  div_step;
    logic  map_load;
    logic  mix_mul;
    logic  mix_wr;
    step_t step;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    logic fb_apply;
  } status_t;

endpackage

FILE: hw/rtl/hpm_ctrl.sv
module hpm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  hpm_pkg::status_t status,
  output hpm_pkg::cmd_t    cmd
);
  import hpm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV, S_LOAD, S_MUL, S_ACC, S_FIN
  } state_t;

  state_t      state;
  step_t       step;
  logic [3:0]  count;
  logic        load_out;

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_FIN) && (!out_valid || !out_stall);

  always_comb begin
    cmd          = '0;
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.div_init = (state == S_PREP);
    cmd.div_step = (state == S_DIV);
    cmd.map_load = (state == S_LOAD);
    cmd.mix_mul  = (state == S_MUL);
    cmd.mix_wr   = (state == S_ACC);
    cmd.step     = step;
    cmd.out_load = load_out;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_FB_YAW;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_PREP;
        end
        S_PREP: begin
          count <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          count <= count + 4'd1;
          if (count == 4'(DIV_STEPS - 1)) state <= S_LOAD;
        end
        S_LOAD: begin
          step  <= status.fb_apply ? STEP_FB_YAW : STEP_SM_YAW;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (step == STEP_ET_RIGHT) begin
            state <= S_FIN;
          end else begin
            step  <= step + 4'd1;
            state <= S_MUL;
          end
        end
        S_FIN: begin
          if (load_out) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/hpm_datapath.sv
module hpm_datapath (
  input  logic               clk,
  input  logic               rst,
  input  hpm_pkg::cmd_t      cmd,
  output hpm_pkg::status_t   status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               face_seen,
  input  logic [15:0]        confidence,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic [15:0]        eye_opening,
  input  logic               values_valid,
  input  logic               tracker_error,
  input  logic signed [15:0] alt_yaw,
  input  logic signed [15:0] alt_pitch,
  input  logic [15:0]        alt_eye,
  output logic signed [15:0] yaw_target,
  output logic signed [15:0] pitch_target,
  output logic [15:0]        eye_target,
  output logic [15:0]        left_eye_target,
  output logic [15:0]        right_eye_target,
  output logic signed [15:0] smoothed_yaw,
  output logic signed [15:0] smoothed_pitch,
  output logic [15:0]        smoothed_eye,
  output logic [1:0]         gate_code,
  output logic               fallback_active,
  output logic [2:0]         fallback_code
);
  import hpm_pkg::*;

  // configuration
  logic [16:0] conf_floor, eye_thr, weight, alpha;
  logic [14:0] deadzone, yaw_max, pitch_max;
  logic [17:0] fb_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      conf_floor <= 17'd32768;
      deadzone   <= 15'd0;
      yaw_max    <= 15'd7680;
      pitch_max  <= 15'd5120;
      eye_thr    <= 17'd0;
      weight     <= ONE_Q16;
      alpha      <= ONE_Q16;
      fb_ctrl    <= 18'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_CONF:  conf_floor <= cfg_data[16:0];
        CFG_DEADZONE:  deadzone   <= cfg_data[14:0];
        CFG_YAW_MAX:   yaw_max    <= cfg_data[14:0];
        CFG_PITCH_MAX: pitch_max  <= cfg_data[14:0];
        CFG_EYE_THR:   eye_thr    <= cfg_data[16:0];
        CFG_WEIGHT:    weight     <= cfg_data[16:0];
        CFG_ALPHA:     alpha      <= cfg_data[16:0];
        CFG_FALLBACK:  fb_ctrl    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [16:0] minc, thr, w, al, fw;
  logic [14:0] ymax, pmax;
  logic        fb_en;

  assign minc  = (conf_floor > ONE_Q16) ? ONE_Q16 : conf_floor;
  assign thr   = (eye_thr > ONE_Q16) ? ONE_Q16 : eye_thr;
  assign w     = (weight > ONE_Q16) ? ONE_Q16 : weight;
  assign al    = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
  assign fw    = (fb_ctrl[16:0] > ONE_Q16) ? ONE_Q16 : fb_ctrl[16:0];
  assign ymax  = (yaw_max < MIN_MAX_DEG) ? MIN_MAX_DEG : yaw_max;
  assign pmax  = (pitch_max < MIN_MAX_DEG) ? MIN_MAX_DEG : pitch_max;
  assign fb_en = fb_ctrl[17];

  // captured item
  logic               c_face, c_valid, c_terr;
  logic [15:0]        c_conf, c_eye, c_aeye;
  logic signed [15:0] c_yaw, c_pitch, c_ayaw, c_apitch;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_face   <= face_seen;
      c_conf   <= confidence;
      c_yaw    <= yaw_angle;
      c_pitch  <= pitch_angle;
      c_eye    <= eye_opening;
      c_valid  <= values_valid;
      c_terr   <= tracker_error;
      c_ayaw   <= alt_yaw;
      c_apitch <= alt_pitch;
      c_aeye   <= alt_eye;
    end
  end

  // gate and fallback codes
  logic [1:0] gate;
  logic [2:0] fcode;
  logic       requested, factive;

  always_comb begin
    gate = GATE_OK;
    if (!c_face) gate = GATE_NO_FACE;
    else if ({1'b0, c_conf} < minc) gate = GATE_LOW_CONF;
    if (!c_valid) gate = GATE_INVALID;
    requested = (gate != GATE_OK) || c_terr;
    if (gate != GATE_OK) fcode = {1'b0, gate};
    else if (c_terr) fcode = FB_TRACKER_ERR;
    else fcode = FB_NONE;
    if (requested && !fb_en) fcode = FB_DISABLED;
    factive = requested && fb_en && (fw != 17'd0);
  end

  assign status.fb_apply = requested && fb_en;

  // eye rescale operands
  logic signed [17:0] eye_num;
  logic [16:0]        eye_den_raw, eye_den;
  logic               eye_pos, eye_sat;

  assign eye_num     = $signed({2'b00, c_eye}) - $signed({1'b0, thr});
  assign eye_den_raw = ONE_Q16 - thr;
  assign eye_den     = (eye_den_raw < EYE_DEN_MIN) ? EYE_DEN_MIN : eye_den_raw;
  assign eye_pos     = (eye_num > 18'sd0);
  assign eye_sat     = (eye_num >= $signed({1'b0, eye_den}));

  // angle operands: magnitude past the deadzone
  logic signed [16:0] yaw_x, pitch_x;
  logic [16:0]        yaw_a, pitch_a, yaw_d, pitch_d;
  logic               yaw_zero, pitch_zero, yaw_sat, pitch_sat;

  assign yaw_x      = {c_yaw[15], c_yaw};
  assign pitch_x    = {c_pitch[15], c_pitch};
  assign yaw_a      = c_yaw[15] ? 17'(-yaw_x) : 17'(yaw_x);
  assign pitch_a    = c_pitch[15] ? 17'(-pitch_x) : 17'(pitch_x);
  assign yaw_zero   = (yaw_a <= {2'b00, deadzone});
  assign pitch_zero = (pitch_a <= {2'b00, deadzone});
  assign yaw_d      = yaw_a - {2'b00, deadzone};
  assign pitch_d    = pitch_a - {2'b00, deadzone};
  assign yaw_sat    = (yaw_d >= {2'b00, ymax});
  assign pitch_sat  = (pitch_d >= {2'b00, pmax});

  // three restoring dividers, one quotient bit per cycle each
  logic [15:0] rem_e, q_e, q_y, q_p;
  logic [14:0] rem_y, rem_p;
  logic [16:0] sh_e;
  logic [15:0] sh_y, sh_p;

  assign sh_e = {rem_e, 1'b0};
  assign sh_y = {rem_y, 1'b0};
  assign sh_p = {rem_p, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_e <= (eye_pos && !eye_sat) ? eye_num[15:0] : 16'd0;
      rem_y <= yaw_d[14:0];
      rem_p <= pitch_d[14:0];
      q_e   <= '0;
      q_y   <= '0;
      q_p   <= '0;
    end else if (cmd.div_step) begin
      if (sh_e >= eye_den) begin
        rem_e <= 16'(sh_e - eye_den);
        q_e   <= {q_e[14:0], 1'b1};
      end else begin
        rem_e <= sh_e[15:0];
        q_e   <= {q_e[14:0], 1'b0};
      end
      if (sh_y >= {1'b0, ymax}) begin
        rem_y <= 15'(sh_y - {1'b0, ymax});
        q_y   <= {q_y[14:0], 1'b1};
      end else begin
        rem_y <= sh_y[14:0];
        q_y   <= {q_y[14:0], 1'b0};
      end
      if (sh_p >= {1'b0, pmax}) begin
        rem_p <= 15'(sh_p - {1'b0, pmax});
        q_p   <= {q_p[14:0], 1'b1};
      end else begin
        rem_p <= sh_p[14:0];
        q_p   <= {q_p[14:0], 1'b0};
      end
    end
  end

  // mapped values; quotients were formed against 2^16, halve for Q1.15
  logic signed [15:0] map_yaw, map_pitch, m_yaw, m_pitch;
  logic [15:0]        map_eye, m_eye;

  always_comb begin
    if (gate != GATE_OK || !eye_pos) map_eye = 16'd0;
    else if (eye_sat) map_eye = 16'hFFFF;
    else map_eye = q_e;

    if (gate != GATE_OK || yaw_zero) map_yaw = 16'sd0;
    else if (yaw_sat) map_yaw = c_yaw[15] ? 16'sh8000 : 16'sh7FFF;
    else if (c_yaw[15]) map_yaw = -$signed({1'b0, q_y[15:1]});
    else map_yaw = $signed({1'b0, q_y[15:1]});

    if (gate != GATE_OK || pitch_zero) map_pitch = 16'sd0;
    else if (pitch_sat) map_pitch = c_pitch[15] ? 16'sh8000 : 16'sh7FFF;
    else if (c_pitch[15]) map_pitch = -$signed({1'b0, q_p[15:1]});
    else map_pitch = $signed({1'b0, q_p[15:1]});
  end

  // smoothing and target state
  logic signed [15:0] s_yaw, s_pitch, ht_yaw, ht_pitch;
  logic [15:0]        s_eye, et_both, et_left, et_right;

  // shared mix unit: x + floor((y - x) * f / 2^16)
  logic signed [17:0] mx_x, mx_y, mx_diff, mx_res;
  logic [16:0]        mx_f;
  logic signed [35:0] mx_prod;

  always_comb begin
    case (cmd.step)
      STEP_FB_YAW:   begin mx_x = 18'(m_yaw);          mx_y = 18'(c_ayaw);   mx_f = fw; end
      STEP_FB_PITCH: begin mx_x = 18'(m_pitch);        mx_y = 18'(c_apitch); mx_f = fw; end
      STEP_FB_EYE:   begin mx_x = {2'b00, m_eye};      mx_y = {2'b00, c_aeye}; mx_f = fw; end
      STEP_SM_YAW:   begin mx_x = 18'(s_yaw);          mx_y = 18'(m_yaw);    mx_f = al; end
      STEP_SM_PITCH: begin mx_x = 18'(s_pitch);        mx_y = 18'(m_pitch);  mx_f = al; end
      STEP_SM_EYE:   begin mx_x = {2'b00, s_eye};      mx_y = {2'b00, m_eye}; mx_f = al; end
      STEP_HT_YAW:   begin mx_x = 18'(ht_yaw);         mx_y = 18'(s_yaw);    mx_f = w; end
      STEP_HT_PITCH: begin mx_x = 18'(ht_pitch);       mx_y = 18'(s_pitch);  mx_f = w; end
      STEP_ET_BOTH:  begin mx_x = {2'b00, et_both};    mx_y = {2'b00, s_eye}; mx_f = w; end
      STEP_ET_LEFT:  begin mx_x = {2'b00, et_left};    mx_y = {2'b00, s_eye}; mx_f = w; end
      STEP_ET_RIGHT: begin mx_x = {2'b00, et_right};   mx_y = {2'b00, s_eye}; mx_f = w; end
      default:       begin mx_x = 18'sd0;              mx_y = 18'sd0;        mx_f = '0; end
    endcase
  end

  assign mx_diff = mx_y - mx_x;
  // a convex blend of two in-range values never leaves that range
  assign mx_res  = mx_x + mx_prod[33:16];

  always_ff @(posedge clk) begin
    if (cmd.mix_mul) mx_prod <= mx_diff * $signed({1'b0, mx_f});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_yaw    <= '0;
      s_pitch  <= '0;
      s_eye    <= '0;
      ht_yaw   <= '0;
      ht_pitch <= '0;
      et_both  <= '0;
      et_left  <= '0;
      et_right <= '0;
    end else if (cmd.mix_wr) begin
      case (cmd.step)
        STEP_SM_YAW:   s_yaw    <= mx_res[15:0];
        STEP_SM_PITCH: s_pitch  <= mx_res[15:0];
        STEP_SM_EYE:   s_eye    <= mx_res[15:0];
        STEP_HT_YAW:   ht_yaw   <= mx_res[15:0];
        STEP_HT_PITCH: ht_pitch <= mx_res[15:0];
        STEP_ET_BOTH:  et_both  <= mx_res[15:0];
        STEP_ET_LEFT:  et_left  <= mx_res[15:0];
        STEP_ET_RIGHT: et_right <= mx_res[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.map_load) begin
      m_yaw   <= map_yaw;
      m_pitch <= map_pitch;
      m_eye   <= map_eye;
    end else if (cmd.mix_wr) begin
      case (cmd.step)
        STEP_FB_YAW:   m_yaw   <= mx_res[15:0];
        STEP_FB_PITCH: m_pitch <= mx_res[15:0];
        STEP_FB_EYE:   m_eye   <= mx_res[15:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      yaw_target       <= ht_yaw;
      pitch_target     <= ht_pitch;
      eye_target       <= et_both;
      left_eye_target  <= et_left;
      right_eye_target <= et_right;
      smoothed_yaw     <= s_yaw;
      smoothed_pitch   <= s_pitch;
      smoothed_eye     <= s_eye;
      gate_code        <= gate;
      fallback_active  <= factive;
      fallback_code    <= fcode;
    end
  end

endmodule

FILE: hw/rtl/head_pose_to_param_mapper_unit.sv
// Channel   Handshake                 Payload
// in        in_valid / in_stall       face_seen .. alt_eye, one port per field
// out       out_valid / out_stall     yaw_target .. fallback_code, one port per field
// cfg       cfg_we, cfg_index         cfg_data (18b), no read-back
//
// Per item, in order: capture, divider set-up, 16 steps of the three side-by-side
// restoring dividers (eye, yaw, pitch), map load, a multiply and an accumulate state
// per pass of the one multiplier (8 without fallback blending, 11 with) and output load.
// rst is synchronous: config to defaults, smoothing and target state cleared.
// A finished item waits in the output register; the next item may be taken and
// worked on meanwhile, and only the output load waits for that register.
module head_pose_to_param_mapper_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [17:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               face_seen,
  input  logic [15:0]        confidence,
  input  logic signed [15:0] yaw_angle,
  input  logic signed [15:0] pitch_angle,
  input  logic [15:0]        eye_opening,
  input  logic               values_valid,
  input  logic               tracker_error,
  input  logic signed [15:0] alt_yaw,
  input  logic signed [15:0] alt_pitch,
  input  logic [15:0]        alt_eye,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] yaw_target,
  output logic signed [15:0] pitch_target,
  output logic [15:0]        eye_target,
  output logic [15:0]        left_eye_target,
  output logic [15:0]        right_eye_target,
  output logic signed [15:0] smoothed_yaw,
  output logic signed [15:0] smoothed_pitch,
  output logic [15:0]        smoothed_eye,
  output logic [1:0]         gate_code,
  output logic               fallback_active,
  output logic [2:0]         fallback_code
);
  import hpm_pkg::*;

  // controller sequences; datapath holds config, item, state and output
  cmd_t    cmd;
  status_t status;

  hpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  hpm_datapath u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .face_seen        (face_seen),
    .confidence       (confidence),
    .yaw_angle        (yaw_angle),
    .pitch_angle      (pitch_angle),
    .eye_opening      (eye_opening),
    .values_valid     (values_valid),
    .tracker_error    (tracker_error),
    .alt_yaw          (alt_yaw),
    .alt_pitch        (alt_pitch),
    .alt_eye          (alt_eye),
    .yaw_target       (yaw_target),
    .pitch_target     (pitch_target),
    .eye_target       (eye_target),
    .left_eye_target  (left_eye_target),
    .right_eye_target (right_eye_target),
    .smoothed_yaw     (smoothed_yaw),
    .smoothed_pitch   (smoothed_pitch),
    .smoothed_eye     (smoothed_eye),
    .gate_code        (gate_code),
    .fallback_active  (fallback_active),
    .fallback_code    (fallback_code)
  );

endmodule

FILE: hw/rtl/hpm_checker.sv
module hpm_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] yaw_target,
  input logic [1:0]         gate_code,
  input logic               fallback_active,
  input logic [2:0]         fallback_code
);
  import hpm_pkg::*;

  // nothing is offered straight out of reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item offered after reset");

  // a taken item keeps the input side busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again without working the item");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(yaw_target)))
    else $error("stalled item changed");

  // a failed gate is reported as its own fallback reason unless disabled
  a_codes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate_code != GATE_OK) |->
      (fallback_code == {1'b0, gate_code} || fallback_code == FB_DISABLED))
    else $error("fallback reason disagrees with gate");

  a_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fallback_active) |->
      (fallback_code != FB_NONE && fallback_code != FB_DISABLED))
    else $error("fallback active without a reason");

endmodule

bind head_pose_to_param_mapper_unit hpm_checker u_hpm_checker (.*);

FILE: tb/tb_head_pose_to_param_mapper_unit.sv
module tb_head_pose_to_param_mapper_unit;
  import hpm_pkg::*;

  // Clock, reset and configuration port
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [17:0] cfg_data = '0;

  // Input channel: one tracker sample per item
  logic in_valid = 1'b0;
  logic in_stall;
  logic face_seen = 1'b0;
  logic [15:0] confidence = '0;
  logic signed [15:0] yaw_angle = '0;
  logic signed [15:0] pitch_angle = '0;
  logic [15:0] eye_opening = '0;
  logic values_valid = 1'b0;
  logic tracker_error = 1'b0;
  logic signed [15:0] alt_yaw = '0;
  logic signed [15:0] alt_pitch = '0;
  logic [15:0] alt_eye = '0;

  // Output channel: one parameter update per item
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] yaw_target, pitch_target, smoothed_yaw, smoothed_pitch;
  logic [15:0] eye_target, left_eye_target, right_eye_target, smoothed_eye;
  logic [1:0] gate_code;
  logic fallback_active;
  logic [2:0] fallback_code;

  typedef struct packed {
    logic        face;
    logic [15:0] conf;
    logic [15:0] yaw;
    logic [15:0] pitch;
    logic [15:0] eye;
    logic        valid;
    logic        terr;
    logic [15:0] ayaw;
    logic [15:0] apitch;
    logic [15:0] aeye;
  } sample_t;

  typedef struct packed {
    logic [15:0] yaw_t;
    logic [15:0] pitch_t;
    logic [15:0] eye_t;
    logic [15:0] left_t;
    logic [15:0] right_t;
    logic [15:0] sm_yaw;
    logic [15:0] sm_pitch;
    logic [15:0] sm_eye;
    logic [1:0]  gate;
    logic        fb_act;
    logic [2:0]  fb_code;
  } update_t;

  // Shadow copy of the register file and of the block's smoothing and target state
  logic [17:0] shadow_cfg [8];
  longint sm_yaw_s, sm_pitch_s, sm_eye_s;
  longint head_s [2];
  longint eyes_s [3];

  update_t pending_updates [$];
  int errors = 0;

  head_pose_to_param_mapper_unit uut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic longint floor_q16(longint x);
    if (x >= 0) return x / 65536;
    return -((-x + 65535) / 65536);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic longint cap_one(longint v);
    return (v > 65536) ? 65536 : v;
  endfunction

  // x*(1-f)+y*f in Q0.16, floored
  function automatic longint blend(longint x, longint y, longint f);
    return floor_q16(x * (65536 - f) + y * f);
  endfunction

  // deadzone, then full-scale divide truncated toward zero
  function automatic longint angle_norm(longint deg, longint dz, longint full);
    longint mag, q;
    mag = (deg < 0) ? -deg : deg;
    if (mag <= dz) return 0;
    q = ((mag - dz) * 32768) / full;
    return (deg > 0) ? clip(q, -32768, 32767) : clip(-q, -32768, 32767);
  endfunction

  function automatic update_t predict_update(sample_t s);
    update_t u;
    longint minc, ymax, pmax, thr, w, al, fw, num, den, my, mp, me;
    logic fb_en, wanted;
    logic [2:0] code;
    logic [1:0] gate;
    minc = cap_one(shadow_cfg[CFG_MIN_CONF][16:0]);
    ymax = shadow_cfg[CFG_YAW_MAX][14:0];
    if (ymax < 256) ymax = 256;
    pmax = shadow_cfg[CFG_PITCH_MAX][14:0];
    if (pmax < 256) pmax = 256;
    thr = cap_one(shadow_cfg[CFG_EYE_THR][16:0]);
    w = cap_one(shadow_cfg[CFG_WEIGHT][16:0]);
    al = cap_one(shadow_cfg[CFG_ALPHA][16:0]);
    fb_en = shadow_cfg[CFG_FALLBACK][17];
    fw = cap_one(shadow_cfg[CFG_FALLBACK][16:0]);
    my = 0;
    mp = 0;
    me = 0;
    wanted = 1'b0;
    code = FB_NONE;
    u = '0;

    // invalid values override both no face and low confidence
    gate = GATE_OK;
    if (!s.face) gate = GATE_NO_FACE;
    else if (s.conf < minc) gate = GATE_LOW_CONF;
    if (!s.valid) gate = GATE_INVALID;
    if (gate != GATE_OK) begin
      wanted = 1'b1;
      code = {1'b0, gate};
    end
    if (s.terr) begin
      wanted = 1'b1;
      if (code == FB_NONE) code = FB_TRACKER_ERR;
    end

    num = longint'(s.eye) - thr;
    den = 65536 - thr;
    if (den < 7) den = 7;
    if (num > 0) me = clip((num * 65536) / den, 0, 65535);
    if (gate == GATE_OK) begin
      my = angle_norm(longint'($signed(s.yaw)), shadow_cfg[CFG_DEADZONE][14:0], ymax);
      mp = angle_norm(longint'($signed(s.pitch)), shadow_cfg[CFG_DEADZONE][14:0], pmax);
    end else begin
      me = 0;
    end

    if (wanted) begin
      if (fb_en) begin
        my = clip(blend(my, longint'($signed(s.ayaw)), fw), -32768, 32767);
        mp = clip(blend(mp, longint'($signed(s.apitch)), fw), -32768, 32767);
        me = clip(blend(me, longint'(s.aeye), fw), 0, 65535);
        u.fb_act = (fw > 0);
      end else begin
        code = FB_DISABLED;
      end
    end

    sm_yaw_s = clip(blend(sm_yaw_s, my, al), -32768, 32767);
    sm_pitch_s = clip(blend(sm_pitch_s, mp, al), -32768, 32767);
    sm_eye_s = clip(blend(sm_eye_s, me, al), 0, 65535);
    head_s[0] = clip(blend(head_s[0], sm_yaw_s, w), -32768, 32767);
    head_s[1] = clip(blend(head_s[1], sm_pitch_s, w), -32768, 32767);
    for (int i = 0; i < 3; i++) eyes_s[i] = clip(blend(eyes_s[i], sm_eye_s, w), 0, 65535);

    u.yaw_t = head_s[0][15:0];
    u.pitch_t = head_s[1][15:0];
    u.eye_t = eyes_s[0][15:0];
    u.left_t = eyes_s[1][15:0];
    u.right_t = eyes_s[2][15:0];
    u.sm_yaw = sm_yaw_s[15:0];
    u.sm_pitch = sm_pitch_s[15:0];
    u.sm_eye = sm_eye_s[15:0];
    u.gate = gate;
    u.fb_code = code;
    return u;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // Output side: random stall per item, check each accepted update
  initial begin : update_checker
    update_t want;
    int hold;
    forever begin
      hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      out_stall <= (hold != 0);
      repeat (hold) @(posedge clk);
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
      if (pending_updates.size() == 0) begin
        report_mismatch("unexpected item", 1, 0);
      end else begin
        want = pending_updates.pop_front();
        if (yaw_target !== want.yaw_t) report_mismatch("yaw_target", yaw_target, want.yaw_t);
        if (pitch_target !== want.pitch_t)
          report_mismatch("pitch_target", pitch_target, want.pitch_t);
        if (eye_target !== want.eye_t) report_mismatch("eye_target", eye_target, want.eye_t);
        if (left_eye_target !== want.left_t)
          report_mismatch("left_eye_target", left_eye_target, want.left_t);
        if (right_eye_target !== want.right_t)
          report_mismatch("right_eye_target", right_eye_target, want.right_t);
        if (smoothed_yaw !== want.sm_yaw)
          report_mismatch("smoothed_yaw", smoothed_yaw, want.sm_yaw);
        if (smoothed_pitch !== want.sm_pitch)
          report_mismatch("smoothed_pitch", smoothed_pitch, want.sm_pitch);
        if (smoothed_eye !== want.sm_eye)
          report_mismatch("smoothed_eye", smoothed_eye, want.sm_eye);
        if (gate_code !== want.gate) report_mismatch("gate_code", gate_code, want.gate);
        if (fallback_active !== want.fb_act)
          report_mismatch("fallback_active", fallback_active, want.fb_act);
        if (fallback_code !== want.fb_code)
          report_mismatch("fallback_code", fallback_code, want.fb_code);
      end
    end
  end

  // Send one sample; prediction is taken when the item is accepted
  task automatic send_sample(sample_t s);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    {face_seen, confidence, yaw_angle, pitch_angle, eye_opening, values_valid,
     tracker_error, alt_yaw, alt_pitch, alt_eye} <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_updates.insert(pending_updates.size(), predict_update(s));
  endtask

  // Let the block drain, then allow for a full item of latency
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_updates.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Register writes only while idle
  task automatic write_reg(logic [2:0] idx, logic [17:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    shadow_cfg[idx] = val;
  endtask

  function automatic sample_t random_sample();
    sample_t s;
    s = 115'({$urandom, $urandom, $urandom, $urandom});
    // mostly samples that pass the gate, so the mapping path is exercised
    s.face = ($urandom_range(0, 9) != 0);
    s.valid = ($urandom_range(0, 9) != 0);
    s.terr = ($urandom_range(0, 7) == 0);
    if ($urandom_range(0, 1)) s.conf = 16'($urandom_range(32768, 65535));
    if ($urandom_range(0, 1)) s.yaw = 16'(int'($urandom_range(0, 16000)) - 8000);
    if ($urandom_range(0, 1)) s.pitch = 16'(int'($urandom_range(0, 16000)) - 8000);
    return s;
  endfunction

  task automatic test_directed();
    sample_t s;
    s = '{face: 1'b1, conf: 16'hFFFF, yaw: 16'h7FFF, pitch: 16'h8000, eye: 16'hFFFF,
          valid: 1'b1, terr: 1'b0, ayaw: 16'h7FFF, apitch: 16'h8000, aeye: 16'hFFFF};
    send_sample(s);
    s.yaw = 16'h8000;
    s.pitch = 16'h7FFF;
    s.eye = 16'h0000;
    send_sample(s);
    s.yaw = 16'sd0;
    s.pitch = -16'sd1;
    send_sample(s);
    s.conf = 16'd32767;                       // just under the threshold
    send_sample(s);
    s.conf = 16'd32768;                       // exactly at the threshold
    send_sample(s);
    s.face = 1'b0;                            // no face outranks low confidence
    s.conf = 16'd0;
    send_sample(s);
    s.valid = 1'b0;                           // invalid values override no face
    send_sample(s);
    s.face = 1'b1;
    s.conf = 16'hFFFF;
    send_sample(s);
    s.valid = 1'b1;
    s.terr = 1'b1;                            // tracker error on a passing sample
    send_sample(s);
    s.face = 1'b0;
    send_sample(s);
    s.face = 1'b1;
    s.conf = 16'd0;
    send_sample(s);
    drain();
  endtask

  task automatic run_phase(int count);
    for (int i = 0; i < count; i++) send_sample(random_sample());
    drain();
  endtask

  task automatic test_fallback_settings();
    // full fallback, zero weight fallback, disabled with weight set, over-range weight clamped
    write_reg(CFG_FALLBACK, 18'h20000 | 18'd65536);
    test_directed();
    write_reg(CFG_FALLBACK, 18'h20000);
    run_phase(30);
    write_reg(CFG_FALLBACK, 18'h1FFFF);
    run_phase(30);
    write_reg(CFG_FALLBACK, 18'h3FFFF);
    run_phase(30);
  endtask

  task automatic test_extreme_registers();
    // out-of-range values: clamped to one, maxima floored at one degree
    write_reg(CFG_MIN_CONF, 18'h1FFFF);
    write_reg(CFG_DEADZONE, 18'h3FFFF);
    write_reg(CFG_YAW_MAX, 18'd0);
    write_reg(CFG_PITCH_MAX, 18'd255);
    write_reg(CFG_EYE_THR, 18'h1FFFF);
    write_reg(CFG_WEIGHT, 18'h1FFFF);
    write_reg(CFG_ALPHA, 18'h1FFFF);
    run_phase(30);
    write_reg(CFG_MIN_CONF, 18'd0);
    write_reg(CFG_DEADZONE, 18'd0);
    write_reg(CFG_YAW_MAX, 18'd256);
    write_reg(CFG_PITCH_MAX, 18'h7FFF);
    write_reg(CFG_EYE_THR, 18'd65530);        // eye denominator floored
    write_reg(CFG_WEIGHT, 18'd0);
    write_reg(CFG_ALPHA, 18'd0);
    run_phase(30);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 10; p++) begin
      write_reg(CFG_MIN_CONF, 18'($urandom_range(0, 65536)));
      write_reg(CFG_DEADZONE, ($urandom_range(0, 1)) ? 18'($urandom_range(0, 2000))
                                                     : 18'($urandom_range(0, 32767)));
      write_reg(CFG_YAW_MAX, 18'($urandom_range(256, 32767)));
      write_reg(CFG_PITCH_MAX, 18'($urandom_range(256, 32767)));
      write_reg(CFG_EYE_THR, 18'($urandom_range(0, 65536)));
      write_reg(CFG_WEIGHT, 18'($urandom_range(0, 65536)));
      write_reg(CFG_ALPHA, 18'($urandom_range(0, 65536)));
      write_reg(CFG_FALLBACK, 18'($urandom_range(0, 196608)));
      run_phase(45);
    end
  endtask

  initial begin
    shadow_cfg[CFG_MIN_CONF] = 18'd32768;
    shadow_cfg[CFG_DEADZONE] = 18'd0;
    shadow_cfg[CFG_YAW_MAX] = 18'd7680;
    shadow_cfg[CFG_PITCH_MAX] = 18'd5120;
    shadow_cfg[CFG_EYE_THR] = 18'd0;
    shadow_cfg[CFG_WEIGHT] = 18'd65536;
    shadow_cfg[CFG_ALPHA] = 18'd65536;
    shadow_cfg[CFG_FALLBACK] = 18'd0;
    sm_yaw_s = 0;
    sm_pitch_s = 0;
    sm_eye_s = 0;
    head_s = '{0, 0};
    eyes_s = '{0, 0, 0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();                          // reset settings, fallback disabled
    run_phase(40);
    test_fallback_settings();
    test_extreme_registers();
    test_random_settings();

    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/hpm_pkg.sv
hw/rtl/hpm_ctrl.sv
hw/rtl/hpm_datapath.sv
hw/rtl/head_pose_to_param_mapper_unit.sv
hw/rtl/hpm_checker.sv
tb/tb_head_pose_to_param_mapper_unit.sv
